// ===== hw/rtl/hbrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hbrp_pkg
// Types and constants for the hex bootloader record parser unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hbrp_pkg;

  // input beat: one character of the image text
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_file;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [2:0]  item_kind;
    logic [31:0] field_value;
    logic [7:0]  array_id;
    logic [15:0] row_number;
    logic [15:0] data_length;
    logic [1:0]  error_code;
    logic        last_in_run;
  } out_item_t;

  // result kinds
  localparam logic [2:0] KIND_PID  = 3'd0;
  localparam logic [2:0] KIND_REV  = 3'd1;
  localparam logic [2:0] KIND_TYPE = 3'd2;
  localparam logic [2:0] KIND_HDR  = 3'd3;
  localparam logic [2:0] KIND_DATA = 3'd4;
  localparam logic [2:0] KIND_OK   = 3'd5;
  localparam logic [2:0] KIND_ERR  = 3'd6;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TRUNC = 2'd1;
  localparam logic [1:0] ERR_HEX   = 2'd2;
  localparam logic [1:0] ERR_SUM   = 2'd3;

  // record start character
  localparam logic [7:0] CHAR_COLON = 8'h3a;

  // result queue depth, pointer width and count width
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  // parse phase, one-hot
  typedef enum logic [8:0] {
    PH_PID   = 9'b0_0000_0001,
    PH_REV   = 9'b0_0000_0010,
    PH_TYPE  = 9'b0_0000_0100,
    PH_IDLE  = 9'b0_0000_1000,
    PH_ARRAY = 9'b0_0001_0000,
    PH_ROW   = 9'b0_0010_0000,
    PH_LEN   = 9'b0_0100_0000,
    PH_DATA  = 9'b0_1000_0000,
    PH_CSUM  = 9'b1_0000_0000
  } phase_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hbrp_stream_if.sv =====
// ----------------------------------------------------------------------------
// hbrp_stream_if
// Valid/ready stream channel carrying one payload per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbrp_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  // producer side
  modport source (output valid, output payload, input ready);
  // consumer side
  modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/hex_bootloader_record_parser_unit.sv =====
// ----------------------------------------------------------------------------
// hex_bootloader_record_parser_unit
// Streaming parser for a text bootloader image: header, records, checksums.
// ----------------------------------------------------------------------------
// Output: a character's first result is on out_ch the cycle after its beat
//   when the queue is empty; a second result is queued behind it.
// Throughput: one character per cycle; results go to a 4-entry queue that
//   drains one beat per cycle and input is taken while two entries are free,
//   so input stalls only when receiver backpressure has filled the queue.
// Reset: synchronous active-low rst_n clears parser state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_bootloader_record_parser_unit
  import hbrp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  hbrp_stream_if.sink   in_ch,
  hbrp_stream_if.source out_ch
);

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  hn_r, hn_nxt;
  logic        pend_r, pend_nxt;
  logic [1:0]  fbc_r, fbc_nxt;
  logic [31:0] pid_r, pid_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  arr_r, arr_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] left_r, left_nxt;
  logic        failed_r, failed_nxt;

  // result queue
  out_item_t       oq_mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wp_r, oq_rp_r;
  logic [OQ_CW-1:0] oq_cnt_r;

  logic        in_fire, out_fire;
  logic [7:0]  ch;
  logic        is_hex;
  logic [3:0]  dval;
  logic [7:0]  byte_val;
  logic [1:0]  res_n;
  logic [2:0]  res_kind [2];
  logic [31:0] res_val  [2];
  logic [1:0]  res_err  [2];
  out_item_t   res      [2];

  assign ch       = in_ch.payload.char_code;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // room for two results before taking a character
  assign in_ch.ready    = (oq_cnt_r <= OQ_CW'(OQ_DEPTH - 2));
  assign out_ch.valid   = (oq_cnt_r != '0);
  assign out_ch.payload = oq_mem_r[oq_rp_r];

  // hex digit decode
  always_comb begin
    is_hex = 1'b1;
    dval   = 4'd0;
    if (ch inside {[8'h30:8'h39]}) begin
      dval = ch[3:0];
    end else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      dval = 4'(ch[2:0] + 3'd1) + 4'd8;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign byte_val = {hn_r, dval};

  // single-pass parse step
  always_comb begin
    phase_nxt  = phase_r;
    hn_nxt     = hn_r;
    pend_nxt   = pend_r;
    fbc_nxt    = fbc_r;
    pid_nxt    = pid_r;
    sum_nxt    = sum_r;
    arr_nxt    = arr_r;
    row_nxt    = row_r;
    len_nxt    = len_r;
    left_nxt   = left_r;
    failed_nxt = failed_r;
    res_n      = 2'd0;
    for (int i = 0; i < 2; i++) begin
      res_kind[i] = KIND_PID;
      res_val[i]  = 32'd0;
      res_err[i]  = ERR_NONE;
    end

    if (in_fire && !failed_r) begin
      if (phase_r == PH_IDLE && !pend_r) begin
        // between records: wait for a record start
        if (ch == CHAR_COLON) begin
          sum_nxt   = 8'd0;
          fbc_nxt   = 2'd0;
          phase_nxt = PH_ARRAY;
        end
      end else if (!is_hex) begin
        res_kind[res_n[0]] = KIND_ERR;
        res_err[res_n[0]]  = ERR_HEX;
        res_n              = res_n + 2'd1;
        failed_nxt         = 1'b1;
      end else if (!pend_r) begin
        hn_nxt   = dval;
        pend_nxt = 1'b1;
      end else begin
        // a full byte
        pend_nxt = 1'b0;
        sum_nxt  = sum_r + byte_val;
        case (phase_r)
          PH_PID: begin
            pid_nxt = {pid_r[23:0], byte_val};
            fbc_nxt = fbc_r + 2'd1;
            if (fbc_r == 2'd3) begin
              res_kind[res_n[0]] = KIND_PID;
              res_val[res_n[0]]  = {pid_r[23:0], byte_val};
              res_n              = res_n + 2'd1;
              phase_nxt          = PH_REV;
            end
          end
          PH_REV: begin
            res_kind[res_n[0]] = KIND_REV;
            res_val[res_n[0]]  = {24'd0, byte_val};
            res_n              = res_n + 2'd1;
            phase_nxt          = PH_TYPE;
          end
          PH_TYPE: begin
            res_kind[res_n[0]] = KIND_TYPE;
            res_val[res_n[0]]  = {24'd0, byte_val};
            res_n              = res_n + 2'd1;
            phase_nxt          = PH_IDLE;
          end
          PH_ARRAY: begin
            arr_nxt   = byte_val;
            fbc_nxt   = 2'd0;
            phase_nxt = PH_ROW;
          end
          PH_ROW: begin
            if (fbc_r == 2'd0) begin
              row_nxt = {byte_val, 8'd0};
              fbc_nxt = 2'd1;
            end else begin
              row_nxt   = {row_r[15:8], byte_val};
              fbc_nxt   = 2'd0;
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            if (fbc_r == 2'd0) begin
              len_nxt = {byte_val, 8'd0};
              fbc_nxt = 2'd1;
            end else begin
              len_nxt            = {len_r[15:8], byte_val};
              fbc_nxt            = 2'd0;
              left_nxt           = {len_r[15:8], byte_val};
              res_kind[res_n[0]] = KIND_HDR;
              res_n              = res_n + 2'd1;
              phase_nxt = ({len_r[15:8], byte_val} != 16'd0) ? PH_DATA : PH_CSUM;
            end
          end
          PH_DATA: begin
            res_kind[res_n[0]] = KIND_DATA;
            res_val[res_n[0]]  = {24'd0, byte_val};
            res_n              = res_n + 2'd1;
            left_nxt           = left_r - 16'd1;
            if (left_r == 16'd1) begin
              phase_nxt = PH_CSUM;
            end
          end
          PH_CSUM: begin
            if (byte_val == 8'(8'd0 - sum_r)) begin
              res_kind[res_n[0]] = KIND_OK;
              res_val[res_n[0]]  = {24'd0, byte_val};
              phase_nxt          = PH_IDLE;
            end else begin
              res_kind[res_n[0]] = KIND_ERR;
              res_err[res_n[0]]  = ERR_SUM;
              failed_nxt         = 1'b1;
            end
            res_n = res_n + 2'd1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end

      // truncation at end of image
      if (in_ch.payload.end_of_file && !failed_nxt &&
          (phase_nxt != PH_IDLE || pend_nxt)) begin
        res_kind[res_n[0]] = KIND_ERR;
        res_err[res_n[0]]  = ERR_TRUNC;
        res_n              = res_n + 2'd1;
        failed_nxt         = 1'b1;
      end
    end

    // assemble result beats with the record fields as updated by this character
    for (int i = 0; i < 2; i++) begin
      res[i].item_kind   = res_kind[i];
      res[i].field_value = res_val[i];
      res[i].array_id    = arr_nxt;
      res[i].row_number  = row_nxt;
      res[i].data_length = len_nxt;
      res[i].error_code  = res_err[i];
    end
    res[0].last_in_run = (res_n == 2'd1);
    res[1].last_in_run = 1'b1;
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PID;
      hn_r     <= 4'd0;
      pend_r   <= 1'b0;
      fbc_r    <= 2'd0;
      pid_r    <= 32'd0;
      sum_r    <= 8'd0;
      arr_r    <= 8'd0;
      row_r    <= 16'd0;
      len_r    <= 16'd0;
      left_r   <= 16'd0;
      failed_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hn_r     <= hn_nxt;
      pend_r   <= pend_nxt;
      fbc_r    <= fbc_nxt;
      pid_r    <= pid_nxt;
      sum_r    <= sum_nxt;
      arr_r    <= arr_nxt;
      row_r    <= row_nxt;
      len_r    <= len_nxt;
      left_r   <= left_nxt;
      failed_r <= failed_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (res_n != 2'd0) begin
      oq_mem_r[oq_wp_r] <= res[0];
    end
    if (res_n == 2'd2) begin
      oq_mem_r[oq_wp_r + OQ_AW'(1)] <= res[1];
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wp_r  <= oq_wp_r + OQ_AW'(res_n);
      oq_rp_r  <= oq_rp_r + OQ_AW'(out_fire);
      oq_cnt_r <= oq_cnt_r + OQ_CW'(res_n) - OQ_CW'(out_fire);
    end
  end

`ifndef SYNTHESIS
  // queue never overfills
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= OQ_CW'(OQ_DEPTH))
    else $error("result queue overflow");

  // after a failure no character yields results
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (failed_r && in_fire) |-> (res_n == 2'd0))
    else $error("result after failure");

  // failure stays until reset
  a_failed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |=> failed_r)
    else $error("failure flag cleared");

  // a pending nibble never exists between records
  a_no_idle_nibble: assert property (@(posedge clk) disable iff (!rst_n)
    !(phase_r == PH_IDLE && pend_r))
    else $error("half byte between records");
`endif

endmodule

`default_nettype wire
